>>> src/s2c_pkg.sv
// ----------------------------------------------------------------------------
// s2c_pkg: shared types and constants of the spherical-to-Cartesian unit
// Fixed-point formats, CORDIC arctangent table and the rotation record that
// travels down the cell chain.
// ----------------------------------------------------------------------------
package s2c_pkg;

	// Field widths of the channels
	localparam int IN_W  = 16;	// Q3.12 angles
	localparam int OUT_W = 16;	// Q1.14 components

	// Internal formats
	localparam int FRAC_SHIFT = 16;	// Q3.12 -> Q3.28
	localparam int WIDE_W     = 34;	// folded angles, up to about 11.1 rad in Q28
	localparam int ANG_W      = 32;	// reduced angle / CORDIC residual, Q28
	localparam int VEC_W      = 32;	// CORDIC x and y, Q1.30
	localparam int PROD_W     = 64;	// Q60 products

	// Angle constants, Q28
	localparam logic signed [WIDE_W-1:0] PI_Q28      = 34'sd843314857;
	localparam logic signed [WIDE_W-1:0] HALF_PI_Q28 = 34'sd421657428;
	localparam logic signed [WIDE_W-1:0] TWO_PI_Q28  = 34'sd1686629713;

	// CORDIC start value: inverse gain, Q30
	localparam logic signed [VEC_W-1:0] GAIN_Q30 = 32'sd652032874;

	// Unit value of the outputs, Q14
	localparam logic signed [OUT_W-1:0] ONE_Q14 = 16'sd16384;

	// Number of CORDIC cells, limited by the table length
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int NUM_CELLS     = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
		: CORDIC_STAGES;
	// stage number, sized to index the arctangent table
	localparam int STAGE_W       = $clog2(ATAN_ENTRIES);

	// atan(2^-i) in Q28
	localparam logic signed [ANG_W-1:0] ATAN_Q28 [ATAN_ENTRIES] = '{
		32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
		32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
		32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
		32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
		32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
		32'sd256,       32'sd128,       32'sd64,       32'sd32
	};

	// One CORDIC rotation in flight; neg flips the final sin and cos
	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
		logic                    neg;
	} rot_t;

	// Azimuth and elevation rotations travel side by side
	typedef struct packed {
		rot_t az;
		rot_t el;
	} rot_pair_t;

endpackage

>>> src/s2c_if.sv
// ----------------------------------------------------------------------------
// s2c_if: valid/ready channels of the spherical-to-Cartesian unit
// Angle channel (azimuth, elevation) and direction channel (dir_x/y/z).
// ----------------------------------------------------------------------------
interface s2c_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [s2c_pkg::IN_W-1:0]     azimuth;
	logic signed [s2c_pkg::IN_W-1:0]     elevation;

	modport source (output valid, output azimuth, output elevation, input ready);
	modport sink   (input valid, input azimuth, input elevation, output ready);
endinterface

interface s2c_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [s2c_pkg::OUT_W-1:0]    dir_x;
	logic signed [s2c_pkg::OUT_W-1:0]    dir_y;
	logic signed [s2c_pkg::OUT_W-1:0]    dir_z;

	modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
	modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

>>> src/s2c_reduce.sv
// ----------------------------------------------------------------------------
// s2c_reduce: angle fold and range reduction
// Folds an elevation beyond +/- pi/2 over the pole, wraps both angles into
// [-pi, pi] in two steps, maps them into [-pi/2, pi/2] and seeds the CORDIC.
// ----------------------------------------------------------------------------
module s2c_reduce (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_vld,
	input  logic signed [s2c_pkg::IN_W-1:0]       azimuth,
	input  logic signed [s2c_pkg::IN_W-1:0]       elevation,
	output logic                                  out_vld,
	output s2c_pkg::rot_pair_t                    pair
);

	localparam int EXT_W = s2c_pkg::WIDE_W - s2c_pkg::IN_W - s2c_pkg::FRAC_SHIFT;

	logic signed [s2c_pkg::WIDE_W-1:0] az_in, el_in;
	logic                              fold;
	logic signed [s2c_pkg::WIDE_W-1:0] az_s1, el_s1, az_s2, el_s2, az_s3, el_s3;
	logic                              vld_s1, vld_s2, vld_s3, vld_s4;
	s2c_pkg::rot_pair_t                pair_s4;

	// One 2pi wrap step
	function automatic logic signed [s2c_pkg::WIDE_W-1:0] wrap(
		input logic signed [s2c_pkg::WIDE_W-1:0] a);
		logic signed [s2c_pkg::WIDE_W-1:0] r;
		if (a > s2c_pkg::PI_Q28) begin
			r = a - s2c_pkg::TWO_PI_Q28;
		end else if (a < -s2c_pkg::PI_Q28) begin
			r = a + s2c_pkg::TWO_PI_Q28;
		end else begin
			r = a;
		end
		return r;
	endfunction

	// Half-plane map into [-pi/2, pi/2] and CORDIC seed
	function automatic s2c_pkg::rot_t seed(input logic signed [s2c_pkg::WIDE_W-1:0] a);
		logic signed [s2c_pkg::WIDE_W-1:0] m;
		s2c_pkg::rot_t                     r;
		r.neg = 1'b0;
		if (a > s2c_pkg::HALF_PI_Q28) begin
			m     = a - s2c_pkg::PI_Q28;
			r.neg = 1'b1;
		end else if (a < -s2c_pkg::HALF_PI_Q28) begin
			m     = a + s2c_pkg::PI_Q28;
			r.neg = 1'b1;
		end else begin
			m = a;
		end
		r.x = s2c_pkg::GAIN_Q30;
		r.y = '0;
		r.z = signed'(m[s2c_pkg::ANG_W-1:0]);
		return r;
	endfunction

	// Q3.12 -> Q28, sign-extended to the wide format
	assign az_in = {{EXT_W{azimuth[s2c_pkg::IN_W-1]}}, azimuth, {s2c_pkg::FRAC_SHIFT{1'b0}}};
	assign el_in = {{EXT_W{elevation[s2c_pkg::IN_W-1]}}, elevation,
		{s2c_pkg::FRAC_SHIFT{1'b0}}};

	// Elevation beyond the poles: beta -> pi - beta, alpha -> alpha - pi
	assign fold = (el_in > s2c_pkg::HALF_PI_Q28) || (el_in < -s2c_pkg::HALF_PI_Q28);

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Fold, two wrap steps, map
	always_ff @(posedge clk) begin
		if (en) begin
			az_s1   <= fold ? az_in - s2c_pkg::PI_Q28 : az_in;
			el_s1   <= fold ? s2c_pkg::PI_Q28 - el_in : el_in;
			az_s2   <= wrap(az_s1);
			el_s2   <= wrap(el_s1);
			az_s3   <= wrap(az_s2);
			el_s3   <= wrap(el_s2);
			pair_s4 <= '{az: seed(az_s3), el: seed(el_s3)};
		end
	end

	assign out_vld = vld_s4;
	assign pair    = pair_s4;

`ifndef NO_ASSERTIONS
	a_az_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (az_s3 <= s2c_pkg::PI_Q28 && az_s3 >= -s2c_pkg::PI_Q28))
		else $error("azimuth not reduced into [-pi, pi]");
	a_el_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (el_s3 <= s2c_pkg::PI_Q28 && el_s3 >= -s2c_pkg::PI_Q28))
		else $error("elevation not reduced into [-pi, pi]");
	a_seed_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (pair_s4.az.z <= s2c_pkg::HALF_PI_Q28
			&& pair_s4.az.z >= -s2c_pkg::HALF_PI_Q28
			&& pair_s4.el.z <= s2c_pkg::HALF_PI_Q28
			&& pair_s4.el.z >= -s2c_pkg::HALF_PI_Q28))
		else $error("CORDIC seed angle outside [-pi/2, pi/2]");
`endif

endmodule

>>> src/s2c_cell.sv
// ----------------------------------------------------------------------------
// s2c_cell: one CORDIC micro-rotation
// Rotates the azimuth and elevation vectors by +/- atan(2^-stage) toward a
// zero residual angle and hands the result to the next cell.
// ----------------------------------------------------------------------------
module s2c_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic [s2c_pkg::STAGE_W-1:0]       stage,
	input  logic                              in_vld,
	input  s2c_pkg::rot_pair_t                in_pair,
	output logic                              out_vld,
	output s2c_pkg::rot_pair_t                out_pair
);

	logic               vld_q;
	s2c_pkg::rot_pair_t pair_q;

	// Shift-add rotation, direction from the residual sign
	function automatic s2c_pkg::rot_t rotate(input s2c_pkg::rot_t r,
		input logic [s2c_pkg::STAGE_W-1:0] k);
		logic signed [s2c_pkg::VEC_W-1:0] xs, ys, xi, yi;
		logic signed [s2c_pkg::ANG_W-1:0] at;
		s2c_pkg::rot_t                    o;
		xi    = r.x;
		yi    = r.y;
		xs    = xi >>> k;
		ys    = yi >>> k;
		at    = s2c_pkg::ATAN_Q28[k];
		o.neg = r.neg;
		if (!r.z[s2c_pkg::ANG_W-1]) begin
			o.x = xi - ys;
			o.y = yi + xs;
			o.z = r.z - at;
		end else begin
			o.x = xi + ys;
			o.y = yi - xs;
			o.z = r.z + at;
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_q <= '{az: rotate(in_pair.az, stage), el: rotate(in_pair.el, stage)};
		end
	end

	assign out_vld  = vld_q;
	assign out_pair = pair_q;

endmodule

>>> src/s2c_out.sv
// ----------------------------------------------------------------------------
// s2c_out: product, rounding and saturation stage
// Applies the half-plane sign, forms cos(beta)*sin(alpha) and
// cos(beta)*cos(alpha), rounds all components to Q1.14 and clamps to +/-1.
// ----------------------------------------------------------------------------
module s2c_out (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  s2c_pkg::rot_pair_t      pair,
	s2c_out_if.source               dir
);

	localparam logic signed [s2c_pkg::PROD_W-1:0] PROD_RND = 64'sh0000_2000_0000_0000;
	localparam int                                PROD_SHIFT = 46;
	localparam logic signed [s2c_pkg::PROD_W-1:0] Y_RND = 64'sd32768;
	localparam int                                Y_SHIFT = 16;
	localparam logic signed [s2c_pkg::PROD_W-1:0] SAT_HI = 64'sd16384;
	localparam logic signed [s2c_pkg::PROD_W-1:0] SAT_LO = -64'sd16384;

	logic                                vld_s1, vld_s2, vld_s3;
	logic signed [s2c_pkg::VEC_W-1:0]    sa_s1, ca_s1, sb_s1, cb_s1;
	logic signed [s2c_pkg::PROD_W-1:0]   px_s2, pz_s2;
	logic signed [s2c_pkg::OUT_W-1:0]    y_s2;
	logic signed [s2c_pkg::OUT_W-1:0]    x_s3, y_s3, z_s3;

	// Clamp to [-1, 1] in Q14
	function automatic logic signed [s2c_pkg::OUT_W-1:0] sat(
		input logic signed [s2c_pkg::PROD_W-1:0] v);
		logic signed [s2c_pkg::OUT_W-1:0] r;
		if (v > SAT_HI) begin
			r = s2c_pkg::ONE_Q14;
		end else if (v < SAT_LO) begin
			r = -s2c_pkg::ONE_Q14;
		end else begin
			r = v[s2c_pkg::OUT_W-1:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// half-plane sign
			sa_s1 <= pair.az.neg ? -pair.az.y : pair.az.y;
			ca_s1 <= pair.az.neg ? -pair.az.x : pair.az.x;
			sb_s1 <= pair.el.neg ? -pair.el.y : pair.el.y;
			cb_s1 <= pair.el.neg ? -pair.el.x : pair.el.x;
			// Q30 x Q30 products; y rounded directly
			px_s2 <= s2c_pkg::PROD_W'(cb_s1) * s2c_pkg::PROD_W'(sa_s1);
			pz_s2 <= s2c_pkg::PROD_W'(cb_s1) * s2c_pkg::PROD_W'(ca_s1);
			y_s2  <= sat((s2c_pkg::PROD_W'(sb_s1) + Y_RND) >>> Y_SHIFT);
			// round half up to Q14 and clamp
			x_s3  <= sat((px_s2 + PROD_RND) >>> PROD_SHIFT);
			z_s3  <= sat((pz_s2 + PROD_RND) >>> PROD_SHIFT);
			y_s3  <= y_s2;
		end
	end

	assign dir.valid = vld_s3;
	assign dir.dir_x = x_s3;
	assign dir.dir_y = y_s3;
	assign dir.dir_z = z_s3;

`ifndef NO_ASSERTIONS
	a_x_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (x_s3 <= s2c_pkg::ONE_Q14 && x_s3 >= -s2c_pkg::ONE_Q14))
		else $error("dir_x outside [-1, 1]");
	a_y_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (y_s3 <= s2c_pkg::ONE_Q14 && y_s3 >= -s2c_pkg::ONE_Q14))
		else $error("dir_y outside [-1, 1]");
	a_z_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (z_s3 <= s2c_pkg::ONE_Q14 && z_s3 >= -s2c_pkg::ONE_Q14))
		else $error("dir_z outside [-1, 1]");
`endif

endmodule

>>> src/spherical_to_cartesian.sv
// ----------------------------------------------------------------------------
// spherical_to_cartesian: azimuth/elevation to unit direction vector
// Fully pipelined CORDIC converter from Q3.12 angles to Q1.14 components.
// ----------------------------------------------------------------------------
// Accepts one angle pair per clock while the pipeline advances and returns one
// direction per pair, in order. The pipeline has four stages of fold and range
// reduction, one CORDIC cell per stage, and three stages of sign, multiply and
// rounding. The whole pipeline advances whenever the output register is empty
// or being taken, so throughput is one transfer per cycle while the downstream
// side keeps ready high. Any 16-bit input is legal; angles are reduced modulo
// 2pi and outputs are clamped to [-1, 1].
// ----------------------------------------------------------------------------
module spherical_to_cartesian (
	input  logic        clk,
	input  logic        arst_n,
	s2c_in_if.sink      angle,
	s2c_out_if.source   dir
);

	logic               en;
	logic               vld_chain  [s2c_pkg::NUM_CELLS+1];
	s2c_pkg::rot_pair_t pair_chain [s2c_pkg::NUM_CELLS+1];

	// Global advance: stall only while a finished result waits
	assign en          = !dir.valid || dir.ready;
	assign angle.ready = en;

	s2c_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (angle.valid),
		.azimuth   (angle.azimuth),
		.elevation (angle.elevation),
		.out_vld   (vld_chain[0]),
		.pair      (pair_chain[0])
	);

	// CORDIC cell chain
	for (genvar i = 0; i < s2c_pkg::NUM_CELLS; i++) begin : g_cell
		s2c_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.stage    (s2c_pkg::STAGE_W'(i)),
			.in_vld   (vld_chain[i]),
			.in_pair  (pair_chain[i]),
			.out_vld  (vld_chain[i+1]),
			.out_pair (pair_chain[i+1])
		);
	end

	s2c_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (vld_chain[s2c_pkg::NUM_CELLS]),
		.pair   (pair_chain[s2c_pkg::NUM_CELLS]),
		.dir    (dir)
	);

endmodule
